// ===== rtl/plk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package plk_pkg;

    // Command opcodes carried with each input word.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    // Control sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Per-cell control issued by the sequencer in the execute cycle.
    typedef struct packed {
        logic valid;   // Slot holds a live entry (index below the count) on a search or remove.
        logic wr;      // Store the command value into this slot.
        logic rm;      // Remove in progress: slots at or past the match shift down.
    } t_cell_ctl;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int POS_W  = 4;

endpackage

`default_nettype wire

// ===== rtl/plk_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One list slot: holds an entry, compares it with the key and takes the
// entry of its upper neighbor when a remove closes the gap.
module plk_cell (
    input  wire                          i_clk,
    input  wire  plk_pkg::t_cell_ctl     i_ctl,
    input  wire  [plk_pkg::DATA_W-1:0]   i_key,
    input  wire  [plk_pkg::DATA_W-1:0]   i_next_entry,
    input  wire                          i_seen_in,
    output logic [plk_pkg::DATA_W-1:0]   o_entry,
    output logic                         o_seen,
    output logic                         o_first
);

    logic [plk_pkg::DATA_W-1:0] r_entry;
    logic [plk_pkg::DATA_W-1:0] n_entry;
    logic                       hit;

    // Match detection and the running "match at or below" chain.
    always_comb begin
        hit     = i_ctl.valid && (r_entry == i_key);
        o_seen  = i_seen_in || hit;
        o_first = hit && !i_seen_in;
    end

    // Next entry: write on insert, shift down on remove at or past the match.
    always_comb begin
        if (i_ctl.wr) begin
            n_entry = i_key;
        end else if (i_ctl.rm && o_seen) begin
            n_entry = i_next_entry;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== rtl/packed_list_insert_search_remove_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Packed list of signed 32-bit words held in a row of DEPTH cells.
// Input channel (i_in_valid / o_in_ready) carries one command word:
// i_opcode (insert, search, remove first match) and i_value.
// Output channel (o_out_valid / i_out_ready) returns one result word per
// command: o_ok, o_position, o_used_count and o_free_slots.
// A command is captured in the idle state and executed in the execute state once
// the output slot is free: every cell compares its entry with the key at once, a
// ripple chain through the row marks the first match, and on remove each cell at
// or past the match loads its upper neighbor at the same clock edge. No new word
// is accepted until the command in hand has executed; the compare chain across
// the row sets the clock.
// The capacity register (i_cfg_we / i_cfg_data) is written at any edge with
// the enable high out of reset; its value is capped at DEPTH where used.
// Reset (i_rst_n low, synchronous) empties the list and sets the capacity to 16.
// If the receiver stalls, the finished result waits in the output register
// and the next command waits in the execute cycle until the slot frees.
module packed_list_insert_search_remove_top #(
    parameter int DEPTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [plk_pkg::CAP_W-1:0]    i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [1:0]                   i_opcode,
    input  wire  signed [plk_pkg::DATA_W-1:0] i_value,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_ok,
    output logic [plk_pkg::POS_W-1:0]    o_position,
    output logic [plk_pkg::CAP_W-1:0]    o_used_count,
    output logic [plk_pkg::CAP_W-1:0]    o_free_slots
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CW     = (CNT_W > plk_pkg::CAP_W) ? CNT_W : plk_pkg::CAP_W;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW     = (IDX_W > plk_pkg::POS_W) ? IDX_W : plk_pkg::POS_W;

    plk_pkg::t_state            r_state;
    plk_pkg::t_state            n_state;
    logic [plk_pkg::CAP_W-1:0]  r_cap;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic [1:0]                 r_op;
    logic [plk_pkg::DATA_W-1:0] r_value;

    logic                       r_out_valid;
    logic                       r_ok;
    logic [plk_pkg::POS_W-1:0]  r_pos;
    logic [plk_pkg::CAP_W-1:0]  r_used;
    logic [plk_pkg::CAP_W-1:0]  r_free;
    logic                       n_ok;
    logic [plk_pkg::POS_W-1:0]  n_pos;
    logic [plk_pkg::CAP_W-1:0]  n_used;
    logic [plk_pkg::CAP_W-1:0]  n_free;

    logic                       in_fire;
    logic                       exec_go;
    logic                       ins_ok;
    logic                       found;
    logic                       is_ins;
    logic                       is_srch;
    logic                       is_rm;
    logic [CW-1:0]              usable;
    logic [CW-1:0]              count_ext;
    logic [CW-1:0]              count_new;
    logic [CW-1:0]              free_full;
    logic [IDX_W-1:0]           match_idx;
    logic [PW-1:0]              match_pos;

    logic [plk_pkg::DATA_W-1:0] entry   [DEPTH];
    logic                       seen    [DEPTH+1];
    logic                       first   [DEPTH];
    plk_pkg::t_cell_ctl         ctl     [DEPTH];

    // Command decode and capacity limits.
    always_comb begin
        is_ins    = (r_op == plk_pkg::OP_INSERT);
        is_srch   = (r_op == plk_pkg::OP_SEARCH);
        is_rm     = (r_op == plk_pkg::OP_REMOVE);
        count_ext = CW'(r_count);
        usable    = (CW'(r_cap) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(r_cap);
        ins_ok    = is_ins && (count_ext < usable);
        found     = seen[DEPTH];
    end

    // Row of cells with the first-match chain running upward.
    assign seen[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [plk_pkg::DATA_W-1:0] next_entry;

            if (g == DEPTH - 1) begin : g_tail
                assign next_entry = '0;
            end else begin : g_body
                assign next_entry = entry[g+1];
            end

            always_comb begin
                ctl[g].valid = (CW'(g) < count_ext) && (is_srch || is_rm);
                ctl[g].wr    = exec_go && ins_ok && (count_ext == CW'(g));
                ctl[g].rm    = exec_go && is_rm;
            end

            plk_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl[g]),
                .i_key        (r_value),
                .i_next_entry (next_entry),
                .i_seen_in    (seen[g]),
                .o_entry      (entry[g]),
                .o_seen       (seen[g+1]),
                .o_first      (first[g])
            );
        end
    endgenerate

    // Encode the one-hot first match into an index.
    always_comb begin
        match_idx = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (first[k]) begin
                match_idx = match_idx | IDX_W'(k);
            end
        end
    end

    // Result word and new count.
    always_comb begin
        n_ok      = 1'b0;
        n_pos     = '0;
        count_new = count_ext;
        match_pos = PW'(match_idx);
        if (ins_ok) begin
            n_ok      = 1'b1;
            n_pos     = count_ext[plk_pkg::POS_W-1:0];
            count_new = count_ext + CW'(1);
        end else if (is_srch && found) begin
            n_ok  = 1'b1;
            n_pos = match_pos[plk_pkg::POS_W-1:0];
        end else if (is_rm && found) begin
            n_ok      = 1'b1;
            count_new = count_ext - CW'(1);
        end
        free_full = usable - count_new;
        n_count   = count_new[CNT_W-1:0];
        n_used    = count_new[plk_pkg::CAP_W-1:0];
        n_free    = (usable > count_new) ? free_full[plk_pkg::CAP_W-1:0] : '0;
    end

    // Sequencer: next state.
    always_comb begin
        case (r_state)
            plk_pkg::ST_IDLE: n_state = in_fire ? plk_pkg::ST_EXEC : plk_pkg::ST_IDLE;
            plk_pkg::ST_EXEC: n_state = exec_go ? plk_pkg::ST_IDLE : plk_pkg::ST_EXEC;
            default:          n_state = plk_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs. No word is taken while reset is held.
    always_comb begin
        case (r_state)
            plk_pkg::ST_IDLE: begin
                o_in_ready = i_rst_n;
                exec_go    = 1'b0;
            end
            plk_pkg::ST_EXEC: begin
                o_in_ready = 1'b0;
                exec_go    = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
                exec_go    = 1'b0;
            end
        endcase
    end

    assign in_fire = i_in_valid && o_in_ready;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plk_pkg::ST_IDLE;
            r_cap       <= plk_pkg::CAP_W'(16);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (exec_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command and result words.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= i_opcode;
            r_value <= i_value;
        end
        if (exec_go) begin
            r_ok   <= n_ok;
            r_pos  <= n_pos;
            r_used <= n_used;
            r_free <= n_free;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_ok;
    assign o_position   = r_pos;
    assign o_used_count = r_used;
    assign o_free_slots = r_free;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = 16;
    localparam int NUM_DIR = 21;
    localparam int NUM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 190;

    // One result word as the block reports it.
    typedef struct packed {
        logic                         ok;
        logic [plk_pkg::POS_W-1:0]    position;
        logic [plk_pkg::CAP_W-1:0]    used;
        logic [plk_pkg::CAP_W-1:0]    free_cnt;
    } t_result_word;

    // One directed command; the expected word is used only when has_want is set.
    typedef struct packed {
        plk_pkg::t_opcode             op;
        logic [plk_pkg::DATA_W-1:0]   val;
        logic                         has_want;
        t_result_word                 want;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [plk_pkg::CAP_W-1:0]      i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic [1:0]                     i_opcode = '0;
    logic [plk_pkg::DATA_W-1:0]     i_value = '0;
    logic                           i_out_ready = 1'b0;
    wire                            o_in_ready;
    wire                            o_out_valid;
    wire                            o_ok;
    wire [plk_pkg::POS_W-1:0]       o_position;
    wire [plk_pkg::CAP_W-1:0]       o_used_count;
    wire [plk_pkg::CAP_W-1:0]       o_free_slots;

    packed_list_insert_search_remove_top #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_opcode(i_opcode),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_ok(o_ok),
        .o_position(o_position),
        .o_used_count(o_used_count),
        .o_free_slots(o_free_slots)
    );

    // Shadow copy of the list and the capacity register.
    logic [plk_pkg::DATA_W-1:0]     list_mem [DEPTH];
    int                             held;
    logic [plk_pkg::CAP_W-1:0]      cap_reg;

    t_result_word                   result_q [$];
    t_stim_row                      dir_rows [NUM_DIR];
    logic [plk_pkg::DATA_W-1:0]     key_pool [8];
    int                    cap_plan [5] = '{16, 1, 0, 31, 2};
    int                    ins_plan [NUM_PHASES] = '{70, 30, 50, 60, 40, 55, 45, 50};

    int errors = 0;
    int n_words = 0;
    int n_stored = 0;
    int n_refused = 0;
    int n_hits = 0;
    int n_cfg = 0;

    // Clock: 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one command to the shadow list and return the word it should produce.
    function automatic t_result_word apply_list_cmd(input plk_pkg::t_opcode op,
                                                    input logic [plk_pkg::DATA_W-1:0] key);
        t_result_word r;
        int lim;
        int hit;
        r = '0;
        lim = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        hit = -1;
        for (int i = 0; i < held; i++) begin
            if (hit < 0 && list_mem[i] == key) hit = i;
        end
        case (op)
            plk_pkg::OP_INSERT: begin
                if (held < lim) begin
                    list_mem[held] = key;
                    r.ok = 1'b1;
                    r.position = held[plk_pkg::POS_W-1:0];
                    held++;
                    n_stored++;
                end else begin
                    n_refused++;
                end
            end
            plk_pkg::OP_SEARCH: begin
                if (hit >= 0) begin
                    r.ok = 1'b1;
                    r.position = hit[plk_pkg::POS_W-1:0];
                    n_hits++;
                end
            end
            plk_pkg::OP_REMOVE: begin
                // Later entries close the gap; the old tail slot is cleared.
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < held; i++) list_mem[i] = list_mem[i + 1];
                    list_mem[held - 1] = '0;
                    held--;
                    r.ok = 1'b1;
                    n_hits++;
                end
            end
            default: ;
        endcase
        r.used = held[plk_pkg::CAP_W-1:0];
        r.free_cnt = (lim > held) ? plk_pkg::CAP_W'(lim - held) : '0;
        n_words++;
        return r;
    endfunction

    // Present one command word after a gap, and log its expectation on acceptance.
    task automatic send_word(input plk_pkg::t_opcode op,
                             input logic [plk_pkg::DATA_W-1:0] val, input int gap,
                             input logic has_want, input t_result_word want);
        t_result_word got;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        got = apply_list_cmd(op, val);
        result_q.push_back(has_want ? want : got);
    endtask

    // Hold off new commands until every outstanding result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [plk_pkg::CAP_W-1:0] cap);
        i_cfg_we <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = cap;
        n_cfg++;
    endtask

    // Stimulus: reset, directed table, then random phases at several capacities.
    initial begin
        int gap;
        int r;
        logic tx_burst;
        plk_pkg::t_opcode op;
        logic [plk_pkg::DATA_W-1:0] val;

        for (int i = 0; i < DEPTH; i++) list_mem[i] = '0;
        held = 0;
        cap_reg = plk_pkg::CAP_W'(16);

        // Fresh list at capacity 16: walk extremes, duplicates, head and tail removal.
        dir_rows = '{
            '{plk_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, 5'd0, 5'd16}},
            '{plk_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd0, 5'd0, 5'd16}},
            '{plk_pkg::OP_NONE,   32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd0, 5'd0, 5'd16}},
            '{plk_pkg::OP_INSERT, 32'h8000_0000, 1'b1, '{1'b1, 4'd0, 5'd1, 5'd15}},
            '{plk_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd1, 5'd2, 5'd14}},
            '{plk_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd2, 5'd3, 5'd13}},
            '{plk_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{1'b1, 4'd3, 5'd4, 5'd12}},
            '{plk_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd4, 5'd5, 5'd11}},
            '{plk_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd1, 5'd5, 5'd11}},
            '{plk_pkg::OP_SEARCH, 32'hFFFF_FFFE, 1'b1, '{1'b0, 4'd0, 5'd5, 5'd11}},
            '{plk_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd0, 5'd4, 5'd12}},
            '{plk_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd3, 5'd4, 5'd12}},
            '{plk_pkg::OP_NONE,   32'h7FFF_FFFF, 1'b1, '{1'b0, 4'd0, 5'd4, 5'd12}},
            '{plk_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b0, '0},
            '{plk_pkg::OP_REMOVE, 32'h8000_0000, 1'b1, '{1'b1, 4'd0, 5'd3, 5'd13}},
            '{plk_pkg::OP_SEARCH, 32'h0000_0000, 1'b0, '0},
            '{plk_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd0, 5'd2, 5'd14}},
            '{plk_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b1, '{1'b0, 4'd0, 5'd2, 5'd14}},
            '{plk_pkg::OP_INSERT, 32'hA5A5_A5A5, 1'b0, '0},
            '{plk_pkg::OP_SEARCH, 32'hA5A5_A5A5, 1'b0, '0},
            '{plk_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd0, 5'd3, 5'd13}}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_DIR; k++) begin
            send_word(dir_rows[k].op, dir_rows[k].val, $urandom_range(0, 19),
                      dir_rows[k].has_want, dir_rows[k].want);
        end

        // Random phases; a small key pool keeps searches and removes hitting.
        tx_burst = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            write_capacity(ph < 5 ? plk_pkg::CAP_W'(cap_plan[ph])
                                  : plk_pkg::CAP_W'($urandom_range(0, 31)));
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7FFF_FFFF;
            key_pool[2] = 32'h0000_0000;
            key_pool[3] = 32'hFFFF_FFFF;
            for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
                if (n == WORDS_PER_PHASE / 2) drain_results();
                r = $urandom_range(0, 99);
                if (r < ins_plan[ph]) begin
                    op = plk_pkg::OP_INSERT;
                end else begin
                    r = $urandom_range(0, 19);
                    op = (r < 9) ? plk_pkg::OP_SEARCH :
                         (r < 18) ? plk_pkg::OP_REMOVE : plk_pkg::OP_NONE;
                end
                val = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
                gap = tx_burst ? 0 : $urandom_range(0, 19);
                send_word(op, val, gap, 1'b0, '0);
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d command words at %0d capacity settings:",
                 n_words, n_cfg);
        $display("%0d stored, %0d refused, %0d key hits on search or remove, %0d mismatches.",
                 n_stored, n_refused, n_hits, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Result side: random stalls with bursts of steady readiness, checking each word.
    initial begin
        int stall;
        int taken;
        logic rx_burst;
        t_result_word want;
        taken = 0;
        rx_burst = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
            if (result_q.size() == 0) begin
                $display("%0t: result word with none expected, expected none actual ok=%0d pos=%0d",
                         $time, o_ok, o_position);
                errors++;
            end else begin
                want = result_q.pop_front();
                if (o_ok !== want.ok) begin
                    $display("%0t: ok mismatch, expected %0d actual %0d", $time, want.ok, o_ok);
                    errors++;
                end
                if (o_position !== want.position) begin
                    $display("%0t: position mismatch, expected %0d actual %0d",
                             $time, want.position, o_position);
                    errors++;
                end
                if (o_used_count !== want.used) begin
                    $display("%0t: used count mismatch, expected %0d actual %0d",
                             $time, want.used, o_used_count);
                    errors++;
                end
                if (o_free_slots !== want.free_cnt) begin
                    $display("%0t: free slots mismatch, expected %0d actual %0d",
                             $time, want.free_cnt, o_free_slots);
                    errors++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("%0t: timeout with %0d results still expected", $time, result_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
